>>> sv/mexp_pkg.sv
// Package for the modular exponentiation block: word width, key register map, sequencer states.
package mexp_pkg;

	localparam int WORD_BITS = 31;
	localparam int CNT_BITS  = $clog2(WORD_BITS);
	localparam int ADDR_BITS = 3;
	localparam int APB_BITS  = 32;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	// Register indexes (byte address bit 2)
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_FINISH
	} state_t;

endpackage

>>> sv/mexp_if.sv
// Valid/ready channel interfaces for ciphertext input items and plaintext result items.
interface mexp_ct_if;
	import mexp_pkg::*;
	logic  valid;
	logic  ready;
	word_t ciphertext;
	modport source (output valid, output ciphertext, input ready);
	modport sink (input valid, input ciphertext, output ready);
endinterface

interface mexp_pt_if;
	import mexp_pkg::*;
	logic  valid;
	logic  ready;
	word_t plaintext;
	modport source (output valid, output plaintext, input ready);
	modport sink (input valid, input plaintext, output ready);
endinterface

>>> sv/modular_exponentiation.sv
// Top level: square-and-multiply modular exponentiation on one shared modular add-double unit.
//
// Usage: write the exponent d (byte address 0) and the modulus n (byte address 4) over the
// APB port while the block is idle; both are 31 bits, reset to d = 0 and n = 1.
// Each ciphertext item x accepted on ct (valid and ready high) yields one plaintext item
// x^d mod n on pt; d = 0 gives 1, and n = 0 gives 0 for any non-zero d.
// The shared unit does one multiplier bit per cycle, (2*acc + addend) mod n. An item
// first has x reduced modulo n, then for every one of the 31 exponent bits it takes a
// squaring plus, for a set bit, a multiply. Zero exponent or zero modulus skips the
// reduction and the loop and goes straight to the result.
// Only one item is in work at a time: ct.ready is high only while the sequencer idles.
// The result sits in an output register; if pt is stalled the next item may still be
// accepted, and its result waits in the sequencer until the register frees.
// Reset (arst_n low, asynchronous) drops any item in work and clears the output valid.
module modular_exponentiation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mexp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [mexp_pkg::APB_BITS-1:0]  pwdata,
	output logic [mexp_pkg::APB_BITS-1:0]  prdata,
	output logic                           pready,
	mexp_ct_if.sink                        ct,
	mexp_pt_if.source                      pt
);
	import mexp_pkg::*;

	localparam int T_BITS = WORD_BITS + 2;
	localparam cnt_t LAST_BIT = cnt_t'(WORD_BITS - 1);

	// Key registers
	word_t exponent_q;
	word_t modulus_q;

	// Datapath registers
	word_t x_q;
	word_t base_q;
	word_t r_q;
	word_t acc_q;
	cnt_t  cnt_q;
	cnt_t  ebit_q;
	word_t pt_data_q;
	logic  pt_valid_q;

	state_t state_q;
	state_t state_d;

	// Sequencer strobes
	logic accept;
	logic step_last;
	logic pt_load;

	// Shared unit signals
	word_t           addend;
	logic [T_BITS-1:0] t_sum;
	logic [T_BITS-1:0] n_ext;
	logic [T_BITS-1:0] n2_ext;
	logic [T_BITS-1:0] t_sub1;
	logic [T_BITS-1:0] t_sub2;
	word_t           acc_next;

	// APB write and read
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= word_t'(1);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_EXPONENT) begin
				exponent_q <= pwdata[WORD_BITS-1:0];
			end else begin
				modulus_q <= pwdata[WORD_BITS-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_MODULUS) begin
			prdata = APB_BITS'(modulus_q);
		end else begin
			prdata = APB_BITS'(exponent_q);
		end
	end

	// Choose the addend: a reduction bit of x, or the multiplicand gated by a multiplier bit
	always_comb begin
		case (state_q)
			ST_REDUCE: addend = word_t'(x_q[cnt_q]);
			ST_SQUARE: addend = r_q[cnt_q] ? r_q : '0;
			ST_MULT:   addend = base_q[cnt_q] ? r_q : '0;
			default:   addend = '0;
		endcase
	end

	// Shared unit: (2*acc + addend) mod n, the sum staying below 3n
	always_comb begin
		n_ext  = T_BITS'(modulus_q);
		n2_ext = {1'b0, modulus_q, 1'b0};
		t_sum  = {1'b0, acc_q, 1'b0} + T_BITS'(addend);
		t_sub1 = t_sum - n_ext;
		t_sub2 = t_sum - n2_ext;
		if (t_sum >= n2_ext) begin
			acc_next = t_sub2[WORD_BITS-1:0];
		end else if (t_sum >= n_ext) begin
			acc_next = t_sub1[WORD_BITS-1:0];
		end else begin
			acc_next = t_sum[WORD_BITS-1:0];
		end
	end

	assign accept    = ct.valid && ct.ready;
	assign step_last = (cnt_q == '0);
	assign pt_load   = (state_q == ST_FINISH) && (!pt_valid_q || pt.ready);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		ct.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ct.ready = 1'b1;
				if (ct.valid) begin
					if (exponent_q == '0 || modulus_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (step_last) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (step_last) begin
					if (exponent_q[ebit_q]) begin
						state_d = ST_MULT;
					end else if (ebit_q == '0) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_MULT: begin
				if (step_last) begin
					if (ebit_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SQUARE;
					end
				end
			end
			ST_FINISH: begin
				if (pt_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath: operand, accumulator, bit counters
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= ct.ciphertext;
				acc_q <= '0;
				cnt_q <= LAST_BIT;
				if (exponent_q == '0) begin
					r_q <= word_t'(1);
				end else begin
					r_q <= '0;
				end
			end
			ST_REDUCE: begin
				if (step_last) begin
					base_q <= acc_next;
					r_q    <= (modulus_q == word_t'(1)) ? '0 : word_t'(1);
					ebit_q <= LAST_BIT;
					acc_q  <= '0;
					cnt_q  <= LAST_BIT;
				end else begin
					acc_q <= acc_next;
					cnt_q <= cnt_q - cnt_t'(1);
				end
			end
			ST_SQUARE: begin
				if (step_last) begin
					r_q   <= acc_next;
					acc_q <= '0;
					cnt_q <= LAST_BIT;
					if (!exponent_q[ebit_q] && ebit_q != '0) begin
						ebit_q <= ebit_q - cnt_t'(1);
					end
				end else begin
					acc_q <= acc_next;
					cnt_q <= cnt_q - cnt_t'(1);
				end
			end
			ST_MULT: begin
				if (step_last) begin
					r_q   <= acc_next;
					acc_q <= '0;
					cnt_q <= LAST_BIT;
					if (ebit_q != '0) begin
						ebit_q <= ebit_q - cnt_t'(1);
					end
				end else begin
					acc_q <= acc_next;
					cnt_q <= cnt_q - cnt_t'(1);
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Output register: load the finished result, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid_q <= 1'b0;
		end else if (pt_load) begin
			pt_valid_q <= 1'b1;
		end else if (pt.ready) begin
			pt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pt_load) begin
			pt_data_q <= r_q;
		end
	end

	assign pt.valid     = pt_valid_q;
	assign pt.plaintext = pt_data_q;

endmodule
